// ===== rtl/core/mhtz_pkg.sv =====
// Shared types, sizes and helpers for the max-heap take-on-zero core.
// Depends on nothing; the heap engine and the top level import it, the RAM does not.
`default_nettype none
package mhtz_pkg;

    localparam int HEAP_DEPTH = 1024;
    localparam int ADDR_W     = $clog2(HEAP_DEPTH);
    localparam int CNT_W      = $clog2(HEAP_DEPTH + 1);
    localparam int KID_W      = ADDR_W + 1;
    localparam int VALUE_W    = 31;
    localparam int CARD_W     = 32;
    localparam int SUM_W      = 63;
    localparam int OUT_W      = 64;

    typedef enum logic [2:0] {
        E_IDLE,
        E_PUSH_CMP,
        E_POP_TOP,
        E_POP_MOVE,
        E_SIFT_L,
        E_SIFT_R,
        E_FIN
    } eng_state_t;

    typedef enum logic [1:0] {
        T_IDLE,
        T_BUSY,
        T_EMIT
    } top_state_t;

    typedef struct packed {
        logic               push;
        logic               pop;
        logic               clear;
        logic [VALUE_W-1:0] value;
    } heap_req_t;

    typedef struct packed {
        logic               done;
        logic               idle;
        logic               full;
        logic               empty;
        logic [VALUE_W-1:0] top;
    } heap_rsp_t;

    function automatic logic [ADDR_W-1:0] parent_of(input logic [ADDR_W-1:0] p);
        logic [ADDR_W-1:0] d;
        d = p - 1'b1;
        return d >> 1;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/core/mhtz_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port with registered data.
// Stands alone; used for the heap storage.
`default_nettype none
module mhtz_ram #(
    parameter int WIDTH = 31,
    parameter int DEPTH = 1024
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule
`default_nettype wire

// ===== rtl/core/mhtz_heap_engine.sv =====
// Heap sequencer: insert with sift-up and remove-max with sift-down over one RAM.
// Depends on mhtz_pkg and mhtz_ram.
`default_nettype none
module mhtz_heap_engine (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire mhtz_pkg::heap_req_t req,
    output mhtz_pkg::heap_rsp_t      rsp
);
    import mhtz_pkg::*;

    eng_state_t         state_reg, state_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [ADDR_W-1:0]  pos_reg, pos_next;
    logic [KID_W-1:0]   kid_reg, kid_next;
    logic [VALUE_W-1:0] hold_reg, hold_next;
    logic [VALUE_W-1:0] left_reg, left_next;
    logic [VALUE_W-1:0] top_reg, top_next;
    logic               done_reg, done_next;

    logic               ram_we, ram_re;
    logic [ADDR_W-1:0]  ram_waddr, ram_raddr;
    logic [VALUE_W-1:0] ram_wdata, ram_rdata;

    logic [ADDR_W-1:0]  up_addr;
    logic [KID_W-1:0]   kid_plus, cnt_ext, nkid;
    logic [VALUE_W-1:0] best_val;
    logic [KID_W-1:0]   best_idx;

    mhtz_ram #(
        .WIDTH(VALUE_W),
        .DEPTH(HEAP_DEPTH)
    ) u_ram (
        .aclk (aclk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .re   (ram_re),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    assign up_addr  = parent_of(pos_reg);
    assign kid_plus = kid_reg + 1'b1;
    assign cnt_ext  = KID_W'(count_reg);

    always_comb begin
        if (state_reg == E_SIFT_R && ram_rdata > left_reg) begin
            best_val = ram_rdata;
            best_idx = kid_plus;
        end else if (state_reg == E_SIFT_R) begin
            best_val = left_reg;
            best_idx = kid_reg;
        end else begin
            best_val = ram_rdata;
            best_idx = kid_reg;
        end
    end

    assign nkid = {best_idx[ADDR_W-1:0], 1'b1};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= E_IDLE;
            count_reg <= '0;
            done_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            done_reg  <= done_next;
        end
        pos_reg  <= pos_next;
        kid_reg  <= kid_next;
        hold_reg <= hold_next;
        left_reg <= left_next;
        top_reg  <= top_next;
    end

    always_comb begin
        state_next = state_reg;
        count_next = count_reg;
        pos_next   = pos_reg;
        kid_next   = kid_reg;
        hold_next  = hold_reg;
        left_next  = left_reg;
        top_next   = top_reg;
        done_next  = 1'b0;
        ram_we     = 1'b0;
        ram_waddr  = pos_reg;
        ram_wdata  = hold_reg;
        ram_re     = 1'b0;
        ram_raddr  = '0;
        unique case (state_reg)
            E_IDLE: begin
                if (req.clear) begin
                    count_next = '0;
                end else if (req.push) begin
                    count_next = count_reg + 1'b1;
                    pos_next   = count_reg[ADDR_W-1:0];
                    hold_next  = req.value;
                    if (count_reg == '0) begin
                        ram_we    = 1'b1;
                        ram_waddr = '0;
                        ram_wdata = req.value;
                        done_next = 1'b1;
                    end else begin
                        ram_re     = 1'b1;
                        ram_raddr  = parent_of(count_reg[ADDR_W-1:0]);
                        state_next = E_PUSH_CMP;
                    end
                end else if (req.pop) begin
                    count_next = count_reg - 1'b1;
                    ram_re     = 1'b1;
                    ram_raddr  = '0;
                    state_next = E_POP_TOP;
                end
            end
            E_PUSH_CMP: begin
                ram_we = 1'b1;
                if (ram_rdata >= hold_reg) begin
                    done_next  = 1'b1;
                    state_next = E_IDLE;
                end else begin
                    ram_wdata = ram_rdata;
                    pos_next  = up_addr;
                    if (up_addr == '0) begin
                        state_next = E_FIN;
                    end else begin
                        ram_re    = 1'b1;
                        ram_raddr = parent_of(up_addr);
                    end
                end
            end
            E_POP_TOP: begin
                top_next = ram_rdata;
                if (count_reg == '0) begin
                    done_next  = 1'b1;
                    state_next = E_IDLE;
                end else begin
                    ram_re     = 1'b1;
                    ram_raddr  = count_reg[ADDR_W-1:0];
                    state_next = E_POP_MOVE;
                end
            end
            E_POP_MOVE: begin
                hold_next = ram_rdata;
                pos_next  = '0;
                kid_next  = KID_W'(1);
                if (cnt_ext > KID_W'(1)) begin
                    ram_re     = 1'b1;
                    ram_raddr  = ADDR_W'(1);
                    state_next = E_SIFT_L;
                end else begin
                    ram_we     = 1'b1;
                    ram_waddr  = '0;
                    ram_wdata  = ram_rdata;
                    done_next  = 1'b1;
                    state_next = E_IDLE;
                end
            end
            E_SIFT_L, E_SIFT_R: begin
                left_next = ram_rdata;
                if (state_reg == E_SIFT_L && kid_plus < cnt_ext) begin
                    ram_re     = 1'b1;
                    ram_raddr  = kid_plus[ADDR_W-1:0];
                    state_next = E_SIFT_R;
                end else if (best_val <= hold_reg) begin
                    ram_we     = 1'b1;
                    done_next  = 1'b1;
                    state_next = E_IDLE;
                end else begin
                    ram_we    = 1'b1;
                    ram_wdata = best_val;
                    pos_next  = best_idx[ADDR_W-1:0];
                    if (nkid < cnt_ext) begin
                        kid_next   = nkid;
                        ram_re     = 1'b1;
                        ram_raddr  = nkid[ADDR_W-1:0];
                        state_next = E_SIFT_L;
                    end else begin
                        state_next = E_FIN;
                    end
                end
            end
            E_FIN: begin
                ram_we     = 1'b1;
                done_next  = 1'b1;
                state_next = E_IDLE;
            end
            default: begin
                state_next = E_IDLE;
            end
        endcase
    end

    assign rsp.done  = done_reg;
    assign rsp.idle  = (state_reg == E_IDLE);
    assign rsp.full  = (count_reg == CNT_W'(HEAP_DEPTH));
    assign rsp.empty = (count_reg == '0);
    assign rsp.top   = top_reg;

endmodule
`default_nettype wire

// ===== rtl/core/max_heap_take_on_zero_core.sv =====
// Top level of the max-heap take-on-zero core: stream ports, running sum, overflow flag.
// Depends on mhtz_pkg and mhtz_heap_engine.
//
//   channel  direction  payload
//   s_       in         tdata[31:0] card_value (signed), tlast last_of_case
//   m_       out        tdata[62:0] total_power, tdata[63] heap_overflowed
//
// An ignored item needs no heap operation; a push does one compare per heap level
// climbed; a removal does up to two RAM reads per level descended, set by the
// single RAM read port. The last item of a case then passes an emit state that loads the result.
// Reset is synchronous and clears control state only; the heap RAM needs no clearing.
// A result that waits on m_tready does not block input until the next last item.
`default_nettype none
module max_heap_take_on_zero_core (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        s_tvalid,
    output logic                             s_tready,
    input  wire logic [mhtz_pkg::CARD_W-1:0] s_tdata,  // [31:0] card_value
    input  wire logic                        s_tlast,
    output logic                             m_tvalid,
    input  wire logic                        m_tready,
    output logic      [mhtz_pkg::OUT_W-1:0]  m_tdata   // [62:0] total_power, [63] heap_overflowed
);
    import mhtz_pkg::*;

    top_state_t         state_reg, state_next;
    logic               last_reg, last_next;
    logic               pop_reg, pop_next;
    logic [SUM_W-1:0]   sum_reg, sum_next;
    logic               flag_reg, flag_next;
    logic               m_tvalid_reg, m_tvalid_next;
    logic [OUT_W-1:0]   m_tdata_reg, m_tdata_next;

    heap_req_t          req;
    heap_rsp_t          rsp;
    logic               s_fire, is_pos, is_zero, emit_fire;
    logic [SUM_W:0]     sum_wide;

    mhtz_heap_engine u_engine (
        .aclk   (aclk),
        .aresetn(aresetn),
        .req    (req),
        .rsp    (rsp)
    );

    assign s_tready = (state_reg == T_IDLE);
    assign s_fire   = s_tvalid && s_tready;
    assign is_zero  = (s_tdata == '0);
    assign is_pos   = !s_tdata[CARD_W-1] && !is_zero;
    assign sum_wide = {1'b0, sum_reg} + (SUM_W + 1)'(rsp.top);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= T_IDLE;
            sum_reg      <= '0;
            flag_reg     <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            sum_reg      <= sum_next;
            flag_reg     <= flag_next;
            m_tvalid_reg <= m_tvalid_next;
        end
        last_reg    <= last_next;
        pop_reg     <= pop_next;
        m_tdata_reg <= m_tdata_next;
    end

    always_comb begin
        state_next    = state_reg;
        last_next     = last_reg;
        pop_next      = pop_reg;
        sum_next      = sum_reg;
        flag_next     = flag_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;
        emit_fire     = 1'b0;
        req.push      = 1'b0;
        req.pop       = 1'b0;
        req.clear     = 1'b0;
        req.value     = s_tdata[VALUE_W-1:0];
        unique case (state_reg)
            T_IDLE: begin
                if (s_fire) begin
                    last_next = s_tlast;
                    pop_next  = is_zero;
                    req.push  = is_pos && !rsp.full;
                    req.pop   = is_zero && !rsp.empty;
                    if (is_pos && rsp.full) begin
                        flag_next = 1'b1;
                    end
                    if (req.push || req.pop) begin
                        state_next = T_BUSY;
                    end else if (s_tlast) begin
                        state_next = T_EMIT;
                    end
                end
            end
            T_BUSY: begin
                if (rsp.done) begin
                    if (pop_reg) begin
                        sum_next = sum_wide[SUM_W] ? {SUM_W{1'b1}} : sum_wide[SUM_W-1:0];
                    end
                    state_next = last_reg ? T_EMIT : T_IDLE;
                end
            end
            T_EMIT: begin
                if (!m_tvalid_reg || m_tready) begin
                    emit_fire     = 1'b1;
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {flag_reg, sum_reg};
                    sum_next      = '0;
                    flag_next     = 1'b0;
                    req.clear     = 1'b1;
                    state_next    = T_IDLE;
                end
            end
            default: begin
                state_next = T_IDLE;
            end
        endcase
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    a_done_in_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        rsp.done |-> state_reg == T_BUSY)
        else $error("heap engine finished an operation the controller did not start");

    a_ready_engine_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> rsp.idle)
        else $error("input accepted while the heap engine is still working");

    a_emit_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        emit_fire |=> sum_reg == '0 && !flag_reg && rsp.empty && m_tvalid)
        else $error("case state not cleared after a result transfer was loaded");

endmodule
`default_nettype wire

// ===== verif/max_heap_take_on_zero_core_test.sv =====
// Self-checking testbench for max_heap_take_on_zero_core: a queue-fed stream driver, a result sink
// with random stalls, and a monitor that predicts each case's sum of taken maxima and overflow flag.
// Depends on mhtz_pkg and the core RTL; reads no files.
module max_heap_take_on_zero_core_test;
    timeunit 1ns;
    timeprecision 1ps;

    import mhtz_pkg::*;

    typedef struct {
        logic [CARD_W-1:0] value;
        logic              last;
    } card_t;

    typedef struct {
        logic [SUM_W-1:0] power;
        logic             overflowed;
    } case_score_t;

    localparam logic [SUM_W-1:0] POWER_CEILING = {SUM_W{1'b1}};
    localparam int RANDOM_ITEMS  = 260;
    localparam int HOLD_CYCLES   = 400;
    localparam int SETTLE_CYCLES = 40;

    logic              aclk     = 1'b0;
    logic              aresetn  = 1'b0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [CARD_W-1:0] s_tdata  = '0;
    logic              s_tlast  = 1'b0;
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [OUT_W-1:0]  m_tdata;

    card_t              pending_cards[$];
    case_score_t        expected_scores[$];
    logic [VALUE_W-1:0] card_pile[$];
    logic [SUM_W-1:0]   taken_total     = '0;
    logic               pile_overflowed = 1'b0;

    int          cards_offered  = 0;
    int          cards_accepted = 0;
    int          results_seen   = 0;
    int          results_sink   = 0;
    int          card_gap       = 0;
    int          result_stall   = 0;
    int          faults         = 0;
    int          hold_mark      = 0;
    logic        sink_blocked   = 1'b0;
    card_t       next_card;
    case_score_t due_score;

    max_heap_take_on_zero_core i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    function automatic void play_card(card_t c);
        int               best;
        logic [SUM_W:0]   wide;
        if (!c.value[CARD_W-1] && c.value != '0) begin
            if (card_pile.size() >= HEAP_DEPTH) begin
                pile_overflowed = 1'b1;
            end else begin
                card_pile.push_back(c.value[VALUE_W-1:0]);
            end
        end else if (c.value == '0 && card_pile.size() > 0) begin
            best = 0;
            for (int i = 1; i < card_pile.size(); i++) begin
                if (card_pile[i] > card_pile[best]) begin
                    best = i;
                end
            end
            wide = taken_total + card_pile[best];
            taken_total = wide[SUM_W] ? POWER_CEILING : wide[SUM_W-1:0];
            card_pile.delete(best);
        end
        if (c.last) begin
            expected_scores.push_back('{taken_total, pile_overflowed});
            card_pile.delete();
            taken_total = '0;
            pile_overflowed = 1'b0;
        end
    endfunction

    function automatic void queue_card(logic [CARD_W-1:0] value, logic last);
        pending_cards.push_back('{value, last});
    endfunction

    function automatic logic [CARD_W-1:0] positive_value();
        logic [CARD_W-1:0] v;
        if ($urandom_range(0, 2) == 0) begin
            v = $urandom_range(1, 8);
        end else begin
            v = $urandom;
            v[CARD_W-1] = 1'b0;
            if (v == '0) begin
                v = 1;
            end
        end
        return v;
    endfunction

    function automatic logic [CARD_W-1:0] random_value();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 45) begin
            return positive_value();
        end else if (pick < 50) begin
            return 32'h7FFF_FFFF;
        end else if (pick < 80) begin
            return '0;
        end
        return $urandom | 32'h8000_0000;
    endfunction

    task automatic drain();
        while (pending_cards.size() != 0 || cards_offered != cards_accepted
               || expected_scores.size() != 0) begin
            @(posedge aclk);
        end
    endtask

    always @(negedge aclk) begin
        if (aresetn && cards_offered == cards_accepted) begin
            if (s_tvalid) begin
                card_gap = ((cards_offered / 128) % 3 == 1) ? 0 : $urandom_range(0, 6);
            end
            if (card_gap > 0 || pending_cards.size() == 0) begin
                if (card_gap > 0) begin
                    card_gap--;
                end
                s_tvalid <= 1'b0;
            end else begin
                next_card = pending_cards.pop_front();
                s_tdata  <= next_card.value;
                s_tlast  <= next_card.last;
                s_tvalid <= 1'b1;
                cards_offered++;
            end
        end
    end

    always @(negedge aclk) begin
        if (results_seen != results_sink) begin
            results_sink = results_seen;
            result_stall = ((results_seen / 16) % 3 == 1) ? 0 : $urandom_range(0, 6);
        end
        if (sink_blocked || result_stall > 0) begin
            if (!sink_blocked) begin
                result_stall--;
            end
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                results_seen++;
                if (expected_scores.size() == 0) begin
                    if (faults < 10) begin
                        $display("Result transfer with no case pending: tdata %h", m_tdata);
                    end
                    faults++;
                end else begin
                    due_score = expected_scores.pop_front();
                    if (m_tdata[SUM_W-1:0] !== due_score.power
                        || m_tdata[SUM_W] !== due_score.overflowed) begin
                        if (faults < 10) begin
                            $display("Result %0d: power expected %0d got %0d, flag %0b got %0b",
                                     results_seen, due_score.power, m_tdata[SUM_W-1:0],
                                     due_score.overflowed, m_tdata[SUM_W]);
                        end
                        faults++;
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                play_card('{s_tdata, s_tlast});
                cards_accepted++;
            end
        end
    end

    initial begin
        @(posedge aclk);
        while (hold_mark == 0 || cards_accepted < hold_mark) begin
            @(posedge aclk);
        end
        sink_blocked = 1'b1;
        repeat (HOLD_CYCLES) @(posedge aclk);
        sink_blocked = 1'b0;
    end

    initial begin
        #10ms;
        $display("max_heap_take_on_zero_core verification failed");
        $finish;
    end

    initial begin
        int queued;
        int case_len;
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Take on an empty queue, negative extremes, ties, and the last item of a case
        // being a push, a take or an ignored value.
        queue_card('0, 1'b1);
        queue_card(32'h8000_0000, 1'b0);
        queue_card(32'hFFFF_FFFF, 1'b1);
        queue_card(32'h7FFF_FFFF, 1'b0);
        queue_card(1, 1'b0);
        queue_card(5, 1'b0);
        queue_card(5, 1'b0);
        queue_card('0, 1'b0);
        queue_card('0, 1'b0);
        queue_card('0, 1'b0);
        queue_card('0, 1'b0);
        queue_card('0, 1'b0);
        queue_card(3, 1'b0);
        queue_card('0, 1'b1);
        queue_card(9, 1'b0);
        queue_card(4, 1'b0);
        queue_card(32'h8000_0001, 1'b1);
        queue_card(2, 1'b0);
        queue_card(32'h7FFF_FFFF, 1'b1);
        queue_card('0, 1'b1);
        drain();

        // One long case builds a deep queue, churns it, then takes on it past empty.
        for (int i = 0; i < 120; i++) begin
            queue_card(positive_value(), 1'b0);
        end
        for (int i = 0; i < 20; i++) begin
            queue_card(($urandom_range(0, 1) == 0) ? '0 : positive_value(), 1'b0);
        end
        for (int i = 0; i < 130; i++) begin
            queue_card('0, 1'b0);
        end
        queue_card('0, 1'b1);
        hold_mark = cards_offered + pending_cards.size() + 60;

        queued = 0;
        while (queued < RANDOM_ITEMS) begin
            case_len = $urandom_range(1, 20);
            for (int j = 0; j < case_len; j++) begin
                queue_card(random_value(), j == case_len - 1);
            end
            queued += case_len;
        end
        drain();
        repeat (SETTLE_CYCLES) @(posedge aclk);

        if (faults == 0 && expected_scores.size() == 0) begin
            $display("max_heap_take_on_zero_core verification clean");
        end else begin
            $display("max_heap_take_on_zero_core verification failed");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/core/mhtz_pkg.sv
rtl/core/mhtz_ram.sv
rtl/core/mhtz_heap_engine.sv
rtl/core/max_heap_take_on_zero_core.sv
verif/max_heap_take_on_zero_core_test.sv
